>>> hw/rtl/ry420_pkg.sv
package ry420_pkg;

	localparam int FRAC_BITS = 8;

	localparam int COEF_W = FRAC_BITS;
	localparam int PROD_W = FRAC_BITS + 8;
	localparam int ACC_W  = FRAC_BITS + 10;
	localparam int SUM_W  = 10;

	localparam logic [COEF_W-1:0] CY_R  = COEF_W'(((257 << FRAC_BITS) + 500) / 1000);
	localparam logic [COEF_W-1:0] CY_G  = COEF_W'(((504 << FRAC_BITS) + 500) / 1000);
	localparam logic [COEF_W-1:0] CY_B  = COEF_W'(((98 << FRAC_BITS) + 500) / 1000);
	localparam logic [COEF_W-1:0] CB_R  = COEF_W'(((148 << FRAC_BITS) + 500) / 1000);
	localparam logic [COEF_W-1:0] CB_G  = COEF_W'(((291 << FRAC_BITS) + 500) / 1000);
	localparam logic [COEF_W-1:0] CB_B  = COEF_W'(((439 << FRAC_BITS) + 500) / 1000);
	localparam logic [COEF_W-1:0] CR_R  = COEF_W'(((439 << FRAC_BITS) + 500) / 1000);
	localparam logic [COEF_W-1:0] CR_G  = COEF_W'(((368 << FRAC_BITS) + 500) / 1000);
	localparam logic [COEF_W-1:0] CR_B  = COEF_W'(((71 << FRAC_BITS) + 500) / 1000);

	localparam logic signed [ACC_W-1:0] Y_BIAS =
		ACC_W'((16 << FRAC_BITS) + (1 << (FRAC_BITS - 1)));
	localparam logic signed [ACC_W-1:0] C_BIAS =
		ACC_W'((128 << FRAC_BITS) + (1 << (FRAC_BITS - 1)));

	typedef enum logic [1:0] {
		CM_ZERO     = 2'd0,
		CM_TOP_LEFT = 2'd1,
		CM_AVERAGE  = 2'd2
	} chroma_mode_t;

	localparam chroma_mode_t CHROMA_MODE_RESET = CM_AVERAGE;

	typedef struct packed {
		logic [7:0] red_00;
		logic [7:0] green_00;
		logic [7:0] blue_00;
		logic [7:0] red_01;
		logic [7:0] green_01;
		logic [7:0] blue_01;
		logic [7:0] red_10;
		logic [7:0] green_10;
		logic [7:0] blue_10;
		logic [7:0] red_11;
		logic [7:0] green_11;
		logic [7:0] blue_11;
	} in_beat_t;

	typedef struct packed {
		logic [7:0] luma_00;
		logic [7:0] luma_01;
		logic [7:0] luma_10;
		logic [7:0] luma_11;
		logic [7:0] chroma_blue;
		logic [7:0] chroma_red;
	} out_beat_t;

	function automatic logic signed [ACC_W-1:0] ext_prod(input logic [PROD_W-1:0] p);
		ext_prod = $signed({{(ACC_W - PROD_W){1'b0}}, p});
	endfunction

	function automatic logic [7:0] finish(input logic signed [ACC_W-1:0] acc);
		logic signed [ACC_W-FRAC_BITS-1:0] whole;
		whole = acc[ACC_W-1:FRAC_BITS];
		if (acc < 0) begin
			finish = 8'd0;
		end else if (whole > 255) begin
			finish = 8'd255;
		end else begin
			finish = whole[7:0];
		end
	endfunction

endpackage

>>> hw/rtl/ry420_pixel.sv
module ry420_pixel
	import ry420_pkg::*;
(
	input  logic       clk,
	input  logic [7:0] red,
	input  logic [7:0] green,
	input  logic [7:0] blue,
	output logic [7:0] luma,
	output logic [7:0] cb,
	output logic [7:0] cr
);

	logic [PROD_W-1:0] y_r_s1, y_g_s1, y_b_s1;
	logic [PROD_W-1:0] cb_r_s1, cb_g_s1, cb_b_s1;
	logic [PROD_W-1:0] cr_r_s1, cr_g_s1, cr_b_s1;
	logic [7:0]        luma_s2, cb_s2, cr_s2;
	logic signed [ACC_W-1:0] y_acc, cb_acc, cr_acc;

	always_ff @(posedge clk) begin
		y_r_s1  <= PROD_W'(red)   * CY_R;
		y_g_s1  <= PROD_W'(green) * CY_G;
		y_b_s1  <= PROD_W'(blue)  * CY_B;
		cb_r_s1 <= PROD_W'(red)   * CB_R;
		cb_g_s1 <= PROD_W'(green) * CB_G;
		cb_b_s1 <= PROD_W'(blue)  * CB_B;
		cr_r_s1 <= PROD_W'(red)   * CR_R;
		cr_g_s1 <= PROD_W'(green) * CR_G;
		cr_b_s1 <= PROD_W'(blue)  * CR_B;
	end

	always_comb begin
		y_acc  = Y_BIAS + ext_prod(y_r_s1) + ext_prod(y_g_s1) + ext_prod(y_b_s1);
		cb_acc = C_BIAS - ext_prod(cb_r_s1) - ext_prod(cb_g_s1) + ext_prod(cb_b_s1);
		cr_acc = C_BIAS + ext_prod(cr_r_s1) - ext_prod(cr_g_s1) - ext_prod(cr_b_s1);
	end

	always_ff @(posedge clk) begin
		luma_s2 <= finish(y_acc);
		cb_s2   <= finish(cb_acc);
		cr_s2   <= finish(cr_acc);
	end

	assign luma = luma_s2;
	assign cb   = cb_s2;
	assign cr   = cr_s2;

endmodule

>>> hw/rtl/rgb_to_ycbcr_420_block_core.sv
// BT.601 studio-range RGB to YCbCr 4:2:0 converter for one 2x2 pixel block per
// beat. A block is taken on every clock edge with start high (busy is always
// low), and its four luma values and one Cb/Cr pair appear for one cycle with
// done high after these registered steps in order: the constant-coefficient
// multiplies, the per-pixel sums and rounding, and the chroma reduction.
// Results are never held back, so the sink must take every beat as it comes.
// The chroma mode register (reset: rounded average) is written by cfg_wr_en
// and cfg_wr_data and should be changed only while no block is in flight.
module rgb_to_ycbcr_420_block_core
	import ry420_pkg::*;
(
	input  logic       clk,
	input  logic       arst_n,
	input  logic       start,
	output logic       busy,
	input  in_beat_t   pixels,
	output logic       done,
	output out_beat_t  result,
	input  logic       cfg_wr_en,
	input  logic [1:0] cfg_wr_data
);

	chroma_mode_t chroma_mode_q;
	logic         valid_s1, valid_s2, valid_s3;
	logic [7:0]   luma [4];
	logic [7:0]   cb   [4];
	logic [7:0]   cr   [4];
	logic [SUM_W-1:0] cb_sum, cr_sum;
	logic [7:0]   cb_sel, cr_sel;
	out_beat_t    result_s3;

	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			chroma_mode_q <= CHROMA_MODE_RESET;
		end else if (cfg_wr_en) begin
			chroma_mode_q <= chroma_mode_t'(cfg_wr_data);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start && !busy;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	ry420_pixel u_px00 (
		.clk(clk), .red(pixels.red_00), .green(pixels.green_00), .blue(pixels.blue_00),
		.luma(luma[0]), .cb(cb[0]), .cr(cr[0])
	);
	ry420_pixel u_px01 (
		.clk(clk), .red(pixels.red_01), .green(pixels.green_01), .blue(pixels.blue_01),
		.luma(luma[1]), .cb(cb[1]), .cr(cr[1])
	);
	ry420_pixel u_px10 (
		.clk(clk), .red(pixels.red_10), .green(pixels.green_10), .blue(pixels.blue_10),
		.luma(luma[2]), .cb(cb[2]), .cr(cr[2])
	);
	ry420_pixel u_px11 (
		.clk(clk), .red(pixels.red_11), .green(pixels.green_11), .blue(pixels.blue_11),
		.luma(luma[3]), .cb(cb[3]), .cr(cr[3])
	);

	always_comb begin
		cb_sum = SUM_W'(cb[0]) + SUM_W'(cb[1]) + SUM_W'(cb[2]) + SUM_W'(cb[3]) + SUM_W'(2);
		cr_sum = SUM_W'(cr[0]) + SUM_W'(cr[1]) + SUM_W'(cr[2]) + SUM_W'(cr[3]) + SUM_W'(2);
		case (chroma_mode_q)
			CM_TOP_LEFT: begin
				cb_sel = cb[0];
				cr_sel = cr[0];
			end
			CM_AVERAGE: begin
				cb_sel = cb_sum[SUM_W-1:2];
				cr_sel = cr_sum[SUM_W-1:2];
			end
			default: begin
				cb_sel = 8'd0;
				cr_sel = 8'd0;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		result_s3.luma_00     <= luma[0];
		result_s3.luma_01     <= luma[1];
		result_s3.luma_10     <= luma[2];
		result_s3.luma_11     <= luma[3];
		result_s3.chroma_blue <= cb_sel;
		result_s3.chroma_red  <= cr_sel;
	end

	assign done   = valid_s3;
	assign result = result_s3;

endmodule

>>> tb/rgb_to_ycbcr_420_block_core_tb.sv
`timescale 1ns / 100ps

module rgb_to_ycbcr_420_block_core_tb
	import ry420_pkg::*;
();

	localparam int FRAC        = 8;
	localparam int SETTLE      = 4;
	localparam int CYCLE_LIMIT = 200000;

	localparam int K_YR = ((257 << FRAC) + 500) / 1000;
	localparam int K_YG = ((504 << FRAC) + 500) / 1000;
	localparam int K_YB = ((98 << FRAC) + 500) / 1000;
	localparam int K_BR = ((148 << FRAC) + 500) / 1000;
	localparam int K_BG = ((291 << FRAC) + 500) / 1000;
	localparam int K_BB = ((439 << FRAC) + 500) / 1000;
	localparam int K_RR = ((439 << FRAC) + 500) / 1000;
	localparam int K_RG = ((368 << FRAC) + 500) / 1000;
	localparam int K_RB = ((71 << FRAC) + 500) / 1000;

	localparam logic [1:0] CM_UNUSED = 2'd3;

	typedef enum logic [1:0] {
		JOB_BEAT,
		JOB_CFG,
		JOB_DRAIN
	} job_kind_t;

	typedef struct {
		job_kind_t  kind;
		logic [1:0] mode;
		in_beat_t   px;
		int         idle_pct;
	} pixel_job_t;

	logic       clk = 1'b0;
	logic       arst_n = 1'b0;
	logic       start = 1'b0;
	logic       busy;
	in_beat_t   pixels = '0;
	logic       done;
	out_beat_t  result;
	logic       cfg_wr_en = 1'b0;
	logic [1:0] cfg_wr_data = 2'd0;

	pixel_job_t pixel_jobs[$];
	out_beat_t  ycc_expected[$];
	logic [1:0] chroma_cfg;
	logic       taken;
	int         settle_cnt = 0;
	int         beats_queued = 0;
	int         beats_taken = 0;
	int         errors = 0;
	int         cycle_cnt = 0;

	rgb_to_ycbcr_420_block_core dut (
		.clk         (clk),
		.arst_n      (arst_n),
		.start       (start),
		.busy        (busy),
		.pixels      (pixels),
		.done        (done),
		.result      (result),
		.cfg_wr_en   (cfg_wr_en),
		.cfg_wr_data (cfg_wr_data)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	function automatic int fixed_to_sample(int acc);
		acc = acc + (1 << (FRAC - 1));
		if (acc < 0)
			acc = 0;
		acc = acc >>> FRAC;
		if (acc > 255)
			acc = 255;
		return acc;
	endfunction

	function automatic out_beat_t predict_ycc(in_beat_t px, logic [1:0] mode);
		int        red[4];
		int        green[4];
		int        blue[4];
		int        cb[4];
		int        cr[4];
		int        luma[4];
		out_beat_t ycc;
		red   = '{px.red_00, px.red_01, px.red_10, px.red_11};
		green = '{px.green_00, px.green_01, px.green_10, px.green_11};
		blue  = '{px.blue_00, px.blue_01, px.blue_10, px.blue_11};
		for (int p = 0; p < 4; p++) begin
			luma[p] = fixed_to_sample((16 << FRAC) + K_YR * red[p] + K_YG * green[p]
				+ K_YB * blue[p]);
			cb[p] = fixed_to_sample((128 << FRAC) - K_BR * red[p] - K_BG * green[p]
				+ K_BB * blue[p]);
			cr[p] = fixed_to_sample((128 << FRAC) + K_RR * red[p] - K_RG * green[p]
				- K_RB * blue[p]);
		end
		ycc.luma_00 = luma[0][7:0];
		ycc.luma_01 = luma[1][7:0];
		ycc.luma_10 = luma[2][7:0];
		ycc.luma_11 = luma[3][7:0];
		case (mode)
			CM_TOP_LEFT: begin
				ycc.chroma_blue = cb[0][7:0];
				ycc.chroma_red  = cr[0][7:0];
			end
			CM_AVERAGE: begin
				ycc.chroma_blue = 8'((cb[0] + cb[1] + cb[2] + cb[3] + 2) >> 2);
				ycc.chroma_red  = 8'((cr[0] + cr[1] + cr[2] + cr[3] + 2) >> 2);
			end
			default: begin
				ycc.chroma_blue = 8'd0;
				ycc.chroma_red  = 8'd0;
			end
		endcase
		return ycc;
	endfunction

	task automatic check_field(string name, logic [7:0] exp_val, logic [7:0] act_val);
		if (act_val !== exp_val) begin
			$error("%s mismatch: expected %0d, got %0d", name, exp_val, act_val);
			errors++;
		end
	endtask

	// accept beats, track the register, check results
	always @(posedge clk or negedge arst_n) begin
		out_beat_t ycc;
		if (!arst_n) begin
			chroma_cfg <= CM_AVERAGE;
			taken <= 1'b0;
		end else begin
			taken <= start && !busy;
			if (cfg_wr_en)
				chroma_cfg <= cfg_wr_data;
			if (start && !busy) begin
				ycc_expected.push_back(predict_ycc(pixels, chroma_cfg));
				beats_taken++;
			end
			if (done) begin
				if (ycc_expected.size() == 0) begin
					$error("result beat with no expectation pending");
					errors++;
				end else begin
					ycc = ycc_expected.pop_front();
					check_field("luma_00", ycc.luma_00, result.luma_00);
					check_field("luma_01", ycc.luma_01, result.luma_01);
					check_field("luma_10", ycc.luma_10, result.luma_10);
					check_field("luma_11", ycc.luma_11, result.luma_11);
					check_field("chroma_blue", ycc.chroma_blue, result.chroma_blue);
					check_field("chroma_red", ycc.chroma_red, result.chroma_red);
				end
			end
		end
	end

	always @(negedge clk) begin
		logic       nxt_start;
		logic       nxt_en;
		logic [1:0] nxt_mode;
		in_beat_t   nxt_px;
		nxt_start = start;
		nxt_en    = 1'b0;
		nxt_mode  = cfg_wr_data;
		nxt_px    = pixels;
		if (ycc_expected.size() == 0)
			settle_cnt++;
		else
			settle_cnt = 0;
		if (arst_n && !(start && !taken)) begin
			nxt_start = 1'b0;
			if (pixel_jobs.size() != 0) begin
				case (pixel_jobs[0].kind)
					JOB_BEAT: begin
						if ($urandom_range(99) >= pixel_jobs[0].idle_pct) begin
							nxt_start = 1'b1;
							nxt_px = pixel_jobs[0].px;
							void'(pixel_jobs.pop_front());
						end
					end
					JOB_CFG: begin
						if (settle_cnt >= SETTLE) begin
							nxt_en = 1'b1;
							nxt_mode = pixel_jobs[0].mode;
							void'(pixel_jobs.pop_front());
						end
					end
					default: begin
						if (settle_cnt >= SETTLE)
							void'(pixel_jobs.pop_front());
					end
				endcase
			end
		end
		start       <= nxt_start;
		cfg_wr_en   <= nxt_en;
		cfg_wr_data <= nxt_mode;
		pixels      <= nxt_px;
	end

	always @(posedge clk) begin
		cycle_cnt <= cycle_cnt + 1;
		if (cycle_cnt == CYCLE_LIMIT) begin
			$display("Simulation FAILED");
			$finish;
		end
	end

	function automatic in_beat_t solid(logic [7:0] r, logic [7:0] g, logic [7:0] b);
		return {4{r, g, b}};
	endfunction

	function automatic logic [7:0] rand_sample();
		case ($urandom_range(9))
			0: return 8'h00;
			1: return 8'hFF;
			default: return 8'($urandom);
		endcase
	endfunction

	task automatic add_beat(in_beat_t px, int idle_pct);
		pixel_job_t job;
		job.kind = JOB_BEAT;
		job.mode = 2'd0;
		job.px = px;
		job.idle_pct = idle_pct;
		pixel_jobs.push_back(job);
		beats_queued++;
	endtask

	task automatic add_ctrl(job_kind_t kind, logic [1:0] mode);
		pixel_job_t job;
		job.kind = kind;
		job.mode = mode;
		job.px = '0;
		job.idle_pct = 0;
		pixel_jobs.push_back(job);
	endtask

	initial begin
		in_beat_t   mixed;
		in_beat_t   px;
		int         phase_idle[4];
		logic [1:0] phase_mode[4];
		phase_idle = '{0, 79, 0, 21};
		phase_mode = '{CM_TOP_LEFT, CM_AVERAGE, CM_UNUSED, CM_ZERO};
		mixed = '0;
		mixed.red_00 = 8'hFF;
		mixed.green_00 = 8'hFF;
		mixed.blue_00 = 8'hFF;
		mixed.red_10 = 8'hFF;
		mixed.blue_11 = 8'hFF;

		// reset mode: rounded average
		add_beat('0, 0);
		add_beat('1, 0);
		add_beat(solid(8'hFF, 8'h00, 8'h00), 0);
		add_beat(solid(8'h00, 8'hFF, 8'h00), 0);
		add_beat(solid(8'h00, 8'h00, 8'hFF), 0);
		add_beat({12{8'hAA}}, 0);
		add_beat({12{8'h55}}, 0);
		add_beat(mixed, 0);
		add_ctrl(JOB_CFG, CM_TOP_LEFT);
		add_beat(mixed, 0);
		add_beat(solid(8'h00, 8'hFF, 8'h00), 0);
		add_beat('1, 0);
		add_ctrl(JOB_CFG, CM_ZERO);
		add_beat(mixed, 0);
		add_beat('1, 0);
		add_ctrl(JOB_CFG, CM_UNUSED);
		add_beat(mixed, 0);
		add_beat(solid(8'h00, 8'h00, 8'hFF), 0);

		for (int ph = 0; ph < 4; ph++) begin
			add_ctrl(JOB_CFG, phase_mode[ph]);
			for (int n = 0; n < 400; n++) begin
				for (int i = 0; i < 12; i++)
					px[8*i +: 8] = rand_sample();
				add_beat(px, phase_idle[ph]);
				if (n == 200)
					add_ctrl(JOB_DRAIN, 2'd0);
			end
		end

		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (beats_taken != beats_queued || ycc_expected.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
		if (errors == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

>>> filelist.f
hw/rtl/ry420_pkg.sv
hw/rtl/ry420_pixel.sv
hw/rtl/rgb_to_ycbcr_420_block_core.sv
tb/rgb_to_ycbcr_420_block_core_tb.sv
